### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/pscheck_pkg.sv
// Shared types and constants of the pending suction check table.
package pscheck_pkg;
   localparam logic [1:0] REQ_CHECK  = 2'd0;
   localparam logic [1:0] REQ_SAMPLE = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   localparam logic [2:0] ST_SUCCESS    = 3'd0;
   localparam logic [2:0] ST_TMO_SEEN   = 3'd1;
   localparam logic [2:0] ST_TMO_UNSEEN = 3'd2;
   localparam logic [2:0] ST_BAD_MASK   = 3'd3;
   localparam logic [2:0] ST_BAD_TMO    = 3'd4;
   localparam logic [2:0] ST_UNCONF     = 3'd5;
   localparam logic [2:0] ST_FULL       = 3'd6;

   localparam logic [1:0] MODE_GE = 2'd1;
   localparam logic [1:0] MODE_LE = 2'd2;

   localparam logic [2:0] CSR_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_MODE      = 3'd1;
   localparam logic [2:0] CSR_LIMIT     = 3'd2;
   localparam logic [2:0] CSR_LEFT      = 3'd3;
   localparam logic [2:0] CSR_CENTER    = 3'd4;
   localparam logic [2:0] CSR_RIGHT     = 3'd5;

   localparam logic [23:0] MAX_TIMEOUT = 24'd8640000;
   localparam logic [31:0] NO_PRESSURE = 32'h8000_0000;

   // Entry word: tag, mask, deadline.
   typedef struct packed {
      logic [7:0]  tag;
      logic [2:0]  mask;
      logic [31:0] deadline;
   } entry_type;

   // Result item as it leaves the block.
   typedef struct packed {
      logic              last;
      logic [2:0]        reached;
      logic [31:0]       right;
      logic [31:0]       center;
      logic [31:0]       left;
      logic [2:0]        status;
      logic [7:0]        tag;
   } result_type;
endpackage

### rtl/pscheck_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module pscheck_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### rtl/pending_suction_check_table.sv
// Top level of the pending suction check table.
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata, tuser = req_type
//  rsp     | out | rsp_tvalid/tready    | tdata, tuser = status, tlast
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
// A check request is taken while idle; a rejection is on rsp the cycle after.
// A sample or tick walks the pending checks in order, reading each entry from the RAM.
// Each removed check has every later entry moved down a slot.
// Input waits while a result sits unaccepted on rsp; a walk holds one result
// back until the next is found or the walk ends, and stalls if rsp is still busy.
// Reset is synchronous; it restores the configuration defaults and clears count, seen bits and tick count.
module pending_suction_check_table #(
   parameter int TABLE_DEPTH = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata: request_tag[7:0], mask[15:8], timeout_ticks[39:16],
   //        sample_valid[40], raw_pressure_a[72:41], b[104:73], c[136:105]
   input  logic [143:0]  req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata: result_tag[7:0], left[39:8], center[71:40], right[103:72],
   //        reached_mask[106:104]
   output logic [111:0]  rsp_tdata,
   // tuser: status[2:0]
   output logic [2:0]    rsp_tuser,
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);
   import pscheck_pkg::*;
   `include "assert_macros.svh"

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = $bits(entry_type);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_EVAL  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   // configuration
   logic [31:0] threshold_ff;
   logic [1:0]  mode_ff, lsrc_ff, csrc_ff, rsrc_ff;
   logic [3:0]  limit_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 32'd96; mode_ff <= 2'd0; limit_ff <= 4'd8;
         lsrc_ff <= 2'd0; csrc_ff <= 2'd1; rsrc_ff <= 2'd2;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data;
            CSR_MODE:      mode_ff <= csr_data[1:0];
            CSR_LIMIT:     limit_ff <= csr_data[3:0];
            CSR_LEFT:      lsrc_ff <= csr_data[1:0];
            CSR_CENTER:    csrc_ff <= csr_data[1:0];
            CSR_RIGHT:     rsrc_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [TABLE_DEPTH-1:0] seen_ff, seen_in;
   logic [31:0] tick_ff, tick_in;
   logic [2:0][31:0] lp_ff, lp_in;
   logic [2:0]  reached_ff, reached_in;
   logic        is_tick_ff, is_tick_in;
   logic [CW-1:0] idx_ff, idx_in;   // entry under test
   logic [CW-1:0] mv_ff, mv_in;     // shift cursor
   result_type  out_ff, out_in;
   logic        out_v_ff, out_v_in;
   result_type  pend_ff, pend_in;   // result held until the next one or the end
   logic        pend_v_ff, pend_v_in;

   // RAM
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;
   pscheck_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // request decode
   logic [7:0]  r_tag, r_mask;
   logic [23:0] r_tmo;
   logic        r_sv;
   logic [31:0] r_p [3];
   assign r_tag  = req_tdata[7:0];
   assign r_mask = req_tdata[15:8];
   assign r_tmo  = req_tdata[39:16];
   assign r_sv   = req_tdata[40];
   assign r_p[0] = req_tdata[72:41];
   assign r_p[1] = req_tdata[104:73];
   assign r_p[2] = req_tdata[136:105];

   function automatic logic [31:0] pick(input logic [1:0] s, input logic [31:0] a,
                                        input logic [31:0] b, input logic [31:0] c);
      case (s)
         2'd1: pick = b;
         2'd2: pick = c;
         default: pick = a;
      endcase
   endfunction

   function automatic logic pass(input logic [31:0] p, input logic [31:0] t,
                                 input logic [1:0] m);
      case (m)
         MODE_GE: pass = $signed(p) >= $signed(t);
         MODE_LE: pass = $signed(p) <= $signed(t);
         default: pass = 1'b0;
      endcase
   endfunction

   // sample remap and compare
   logic [2:0][31:0] s_p;
   logic [2:0]       s_reached;
   assign s_p[0] = pick(lsrc_ff, r_p[0], r_p[1], r_p[2]);
   assign s_p[1] = pick(csrc_ff, r_p[0], r_p[1], r_p[2]);
   assign s_p[2] = pick(rsrc_ff, r_p[0], r_p[1], r_p[2]);
   assign s_reached = {pass(s_p[2], threshold_ff, mode_ff),
                       pass(s_p[1], threshold_ff, mode_ff),
                       pass(s_p[0], threshold_ff, mode_ff)};

   // table full against both the limit register and the depth
   logic table_full;
   assign table_full = (count_ff >= CW'(TABLE_DEPTH)) ||
                       ({{(32-CW){1'b0}}, count_ff} >= {28'd0, limit_ff});

   logic out_free;
   assign out_free = !out_v_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;

   // entry test: deadline reached on a tick, all collectors passed on a sample
   logic [31:0] age;
   logic        hit;
   assign age = tick_ff - rd_data.deadline;
   assign hit = is_tick_ff ? !age[31] : ((reached_ff & rd_data.mask) == rd_data.mask);

   logic [CW-1:0] idx_nx, mv_nx, mv_pv, cnt_pv;
   assign idx_nx = idx_ff + 1'b1;
   assign mv_nx  = mv_ff + 1'b1;
   assign mv_pv  = mv_ff - 1'b1;
   assign cnt_pv = count_ff - 1'b1;

   always_comb begin
      result_type r;
      state_in = state_ff; count_in = count_ff; seen_in = seen_ff; tick_in = tick_ff;
      lp_in = lp_ff; reached_in = reached_ff; is_tick_in = is_tick_ff;
      idx_in = idx_ff; mv_in = mv_ff;
      out_in = out_ff; out_v_in = out_v_ff && !rsp_tready;
      pend_in = pend_ff; pend_v_in = pend_v_ff;
      wr_en = 1'b0; wr_addr = count_ff[AW-1:0]; wr_data = '0; rd_addr = idx_ff[AW-1:0];
      r = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               case (req_tuser)
                  REQ_CHECK: begin
                     r.tag = r_tag; r.left = NO_PRESSURE; r.center = NO_PRESSURE;
                     r.right = NO_PRESSURE; r.last = 1'b1;
                     if (r_mask == 8'd0 || (r_mask & 8'hf8) != 8'd0) r.status = ST_BAD_MASK;
                     else if (r_tmo == 24'd0 || r_tmo > MAX_TIMEOUT) r.status = ST_BAD_TMO;
                     else if (mode_ff != MODE_GE && mode_ff != MODE_LE) r.status = ST_UNCONF;
                     else if (table_full) r.status = ST_FULL;
                     else r.status = ST_SUCCESS;
                     if (r.status == ST_SUCCESS) begin
                        // stored at the end of the packed table, no result
                        wr_en = 1'b1;
                        wr_data.tag = r_tag; wr_data.mask = r_mask[2:0];
                        wr_data.deadline = tick_ff + {8'd0, r_tmo};
                        seen_in[count_ff[AW-1:0]] = 1'b0;
                        count_in = count_ff + 1'b1;
                     end else begin
                        out_in = r; out_v_in = 1'b1;
                     end
                  end
                  REQ_SAMPLE: begin
                     if (r_sv) begin
                        lp_in = s_p; reached_in = s_reached;
                        is_tick_in = 1'b0; idx_in = '0;
                        state_in = S_READ;
                     end
                  end
                  REQ_TICK: begin
                     tick_in = tick_ff + 32'd1;
                     is_tick_in = 1'b1; idx_in = '0;
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            // read of entry idx issued this cycle
            if (idx_ff >= count_ff) state_in = S_FIN;
            else state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!is_tick_ff) seen_in[idx_ff[AW-1:0]] = 1'b1;
            if (!hit) begin
               idx_in = idx_nx;
               rd_addr = idx_nx[AW-1:0];
               state_in = (idx_nx >= count_ff) ? S_FIN : S_EVAL;
            end else if (!pend_v_ff || out_free) begin
               r.tag = rd_data.tag;
               if (is_tick_ff) begin
                  r.status = seen_ff[idx_ff[AW-1:0]] ? ST_TMO_SEEN : ST_TMO_UNSEEN;
               end else r.status = ST_SUCCESS;
               if (r.status == ST_TMO_UNSEEN) begin
                  r.left = NO_PRESSURE; r.center = NO_PRESSURE; r.right = NO_PRESSURE;
                  r.reached = 3'd0;
               end else begin
                  r.left = lp_ff[0]; r.center = lp_ff[1]; r.right = lp_ff[2];
                  r.reached = reached_ff;
               end
               // the held result is not the last one
               if (pend_v_ff) begin
                  out_in = pend_ff; out_v_in = 1'b1;
               end
               pend_in = r; pend_v_in = 1'b1;
               mv_in = idx_nx;
               rd_addr = idx_nx[AW-1:0];
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // rd_data holds entry mv; move it to mv-1
            if (mv_ff >= count_ff) begin
               count_in = cnt_pv;
               seen_in[cnt_pv[AW-1:0]] = 1'b0;
               state_in = S_READ;
            end else begin
               wr_en = 1'b1; wr_addr = mv_pv[AW-1:0]; wr_data = rd_data;
               seen_in[mv_pv[AW-1:0]] = seen_ff[mv_ff[AW-1:0]];
               mv_in = mv_nx;
               rd_addr = mv_nx[AW-1:0];
            end
         end
         S_FIN: begin
            // release the held result as the last of the run
            if (!pend_v_ff) state_in = S_IDLE;
            else if (out_free) begin
               out_in = pend_ff; out_in.last = 1'b1; out_v_in = 1'b1;
               pend_v_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; seen_ff <= '0; tick_ff <= '0;
         reached_ff <= '0; out_v_ff <= 1'b0; pend_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; seen_ff <= seen_in;
         tick_ff <= tick_in; reached_ff <= reached_in; out_v_ff <= out_v_in;
         pend_v_ff <= pend_v_in;
      end
      lp_ff <= lp_in; is_tick_ff <= is_tick_in; idx_ff <= idx_in; mv_ff <= mv_in;
      out_ff <= out_in; pend_ff <= pend_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'd0, out_ff.reached, out_ff.right, out_ff.center,
                        out_ff.left, out_ff.tag};
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last;

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(TABLE_DEPTH))
   `ASSERT_NEXT(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req_tready)
endmodule

### sim/pending_suction_check_table_tb.sv
// Self-checking testbench of the pending suction check table: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module pending_suction_check_table_tb;
   import pscheck_pkg::*;

   // One expected or observed result transfer.
   typedef struct {
      logic [7:0]  tag;
      logic [2:0]  status;
      logic [31:0] left;
      logic [31:0] center;
      logic [31:0] right;
      logic [2:0]  reached;
      logic        last;
   } suction_result_type;

   // One pending check as the predictor keeps it.
   typedef struct {
      logic [7:0]  tag;
      logic [2:0]  mask;
      logic [31:0] deadline;
      bit          seen;
   } pending_check_type;

   // Predicts the table and checks its results in order.
   class suction_scoreboard;
      logic [31:0]        thr;
      logic [1:0]         mode;
      logic [3:0]         limit;
      logic [1:0]         src[3];
      pending_check_type  checks[$];
      logic [31:0]        ticks;
      logic [31:0]        last_press[3];
      logic [2:0]         last_reached;
      suction_result_type awaited[$];
      int                 errors;
      int                 matched;

      function new();
         thr = 32'd96;
         mode = 2'd0;
         limit = 4'd8;
         src[0] = 2'd0;
         src[1] = 2'd1;
         src[2] = 2'd2;
         ticks = '0;
         last_press[0] = '0;
         last_press[1] = '0;
         last_press[2] = '0;
         last_reached = '0;
         errors = 0;
         matched = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            CSR_THRESHOLD: thr = data;
            CSR_MODE: mode = data[1:0];
            CSR_LIMIT: limit = data[3:0];
            CSR_LEFT: src[0] = data[1:0];
            CSR_CENTER: src[1] = data[1:0];
            CSR_RIGHT: src[2] = data[1:0];
            default: ;
         endcase
      endfunction

      function void push_result(logic [7:0] tag, logic [2:0] st, bit seen);
         suction_result_type r;
         r.tag = tag;
         r.status = st;
         r.left = seen ? last_press[0] : NO_PRESSURE;
         r.center = seen ? last_press[1] : NO_PRESSURE;
         r.right = seen ? last_press[2] : NO_PRESSURE;
         r.reached = seen ? last_reached : 3'd0;
         r.last = 1'b0;
         awaited = {awaited, r};
      endfunction

      function bit reaches(logic [31:0] p);
         if (mode == MODE_GE) return $signed(p) >= $signed(thr);
         if (mode == MODE_LE) return $signed(p) <= $signed(thr);
         return 1'b0;
      endfunction

      // Note one accepted input transfer and queue the results it causes.
      function void note_item(logic [1:0] kind, logic [143:0] d);
         logic [7:0]  tag;
         logic [7:0]  msk;
         logic [23:0] tmo;
         logic [31:0] raw[3];
         int          eff;
         int          n;
         int          i;
         pending_check_type c;
         tag = d[7:0];
         msk = d[15:8];
         tmo = d[39:16];
         raw[0] = d[72:41];
         raw[1] = d[104:73];
         raw[2] = d[136:105];
         n = 0;
         if (kind == REQ_CHECK) begin
            eff = (limit < 8) ? limit : 8;
            if (msk == 8'd0 || (msk & 8'hf8) != 8'd0) begin
               push_result(tag, ST_BAD_MASK, 1'b0);
               n = 1;
            end else if (tmo == 24'd0 || tmo > MAX_TIMEOUT) begin
               push_result(tag, ST_BAD_TMO, 1'b0);
               n = 1;
            end else if (mode != MODE_GE && mode != MODE_LE) begin
               push_result(tag, ST_UNCONF, 1'b0);
               n = 1;
            end else if (checks.size() >= eff) begin
               push_result(tag, ST_FULL, 1'b0);
               n = 1;
            end else begin
               c.tag = tag;
               c.mask = msk[2:0];
               c.deadline = ticks + {8'd0, tmo};
               c.seen = 1'b0;
               checks = {checks, c};
            end
         end else if (kind == REQ_SAMPLE) begin
            if (!d[40]) return;
            // Source three falls back to position a.
            for (i = 0; i < 3; i++)
               last_press[i] = (src[i] == 2'd1) ? raw[1] : (src[i] == 2'd2) ? raw[2] : raw[0];
            last_reached = '0;
            for (i = 0; i < 3; i++)
               if (reaches(last_press[i])) last_reached[i] = 1'b1;
            i = 0;
            while (i < checks.size()) begin
               checks[i].seen = 1'b1;
               if ((last_reached & checks[i].mask) == checks[i].mask) begin
                  push_result(checks[i].tag, ST_SUCCESS, 1'b1);
                  n++;
                  checks.delete(i);
               end else begin
                  i++;
               end
            end
         end else if (kind == REQ_TICK) begin
            ticks = ticks + 32'd1;
            i = 0;
            while (i < checks.size()) begin
               if (!((ticks - checks[i].deadline) >> 31)) begin
                  push_result(checks[i].tag, checks[i].seen ? ST_TMO_SEEN : ST_TMO_UNSEEN,
                              checks[i].seen);
                  n++;
                  checks.delete(i);
               end else begin
                  i++;
               end
            end
         end
         if (n > 0) awaited[awaited.size() - 1].last = 1'b1;
      endfunction

      // Compare one result transfer with the oldest expectation.
      function void check_result(suction_result_type got);
         suction_result_type x;
         if (awaited.size() == 0) begin
            $error("unexpected result: tag %0h status %0d", got.tag, got.status);
            errors++;
            return;
         end
         x = awaited.pop_front();
         matched++;
         if (got.tag !== x.tag) begin
            $error("result_tag expected %0h got %0h", x.tag, got.tag); errors++;
         end
         if (got.status !== x.status) begin
            $error("status expected %0d got %0d", x.status, got.status); errors++;
         end
         if (got.left !== x.left) begin
            $error("left_pressure expected %0h got %0h", x.left, got.left); errors++;
         end
         if (got.center !== x.center) begin
            $error("center_pressure expected %0h got %0h", x.center, got.center); errors++;
         end
         if (got.right !== x.right) begin
            $error("right_pressure expected %0h got %0h", x.right, got.right); errors++;
         end
         if (got.reached !== x.reached) begin
            $error("reached_mask expected %0h got %0h", x.reached, got.reached); errors++;
         end
         if (got.last !== x.last) begin
            $error("last_of_run expected %0b got %0b", x.last, got.last); errors++;
         end
      endfunction
   endclass

   localparam logic [1:0] MODE_OFF = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [1:0] REQ_SPARE = 2'd3;
   localparam int IDLE_WAIT = 60;
   localparam int STALL_LIMIT = 4000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [143:0]  req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [111:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid;
   logic          csr_ready;
   logic [2:0]    csr_index;
   logic [31:0]   csr_data;

   suction_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   int sent_items = 0;
   logic [31:0] cur_thr = 32'd96;

   pending_suction_check_table dut (.*);

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Result side: check each transfer, then choose next ready.
   always @(posedge clock) begin
      suction_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tag = rsp_tdata[7:0];
         got.left = rsp_tdata[39:8];
         got.center = rsp_tdata[71:40];
         got.right = rsp_tdata[103:72];
         got.reached = rsp_tdata[106:104];
         got.status = rsp_tuser;
         got.last = rsp_tlast;
         sb.check_result(got);
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("pending_suction_check_table verification failed");
         $finish;
      end
   end

   function automatic logic [143:0] pack_req(logic [31:0] tag, logic [31:0] msk,
                                             logic [31:0] tmo, logic [31:0] sv,
                                             logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c);
      return {7'd0, c, b, a, sv[0], tmo[23:0], msk[7:0], tag[7:0]};
   endfunction

   task automatic send_item(logic [1:0] kind, logic [143:0] d);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, d);
      sent_items++;
   endtask

   // Valid is lowered by the caller after the last register.
   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      if (idx == CSR_THRESHOLD) cur_thr = data;
   endtask

   // Let the block drain before touching registers.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic load_regs(logic [31:0] thr, logic [1:0] mode, logic [3:0] lim,
                            logic [1:0] l, logic [1:0] c, logic [1:0] r);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_MODE, {$urandom_range(0, 1) ? $urandom : 32'd0} & 32'hffff_fffc | mode);
      write_reg(CSR_LIMIT, {$urandom_range(0, 1) ? $urandom : 32'd0} & 32'hffff_fff0 | lim);
      write_reg(CSR_LEFT, {30'd0, l});
      write_reg(CSR_CENTER, {30'd0, c});
      write_reg(CSR_RIGHT, {30'd0, r});
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed checks, samples near the threshold and ticks.
   task automatic send_random();
      int          pick;
      logic [7:0]  msk;
      logic [23:0] tmo;
      logic [31:0] p[3];
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         msk = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 7)) : 8'($urandom);
         case ($urandom_range(0, 9))
            0: tmo = 24'($urandom_range(1, 8640000));
            1: tmo = 24'($urandom);
            default: tmo = 24'($urandom_range(1, 6));
         endcase
         send_item(REQ_CHECK, pack_req($urandom, {24'd0, msk}, {8'd0, tmo}, $urandom,
                                       $urandom, $urandom, $urandom));
      end else if (pick < 65) begin
         for (int i = 0; i < 3; i++)
            p[i] = $urandom_range(0, 1) ? cur_thr + 32'($urandom_range(0, 8)) - 32'd4
                                        : $urandom;
         send_item(REQ_SAMPLE, pack_req($urandom, $urandom, $urandom,
                                        {31'd0, $urandom_range(0, 9) != 0},
                                        p[0], p[1], p[2]));
      end else if (pick < 97) begin
         send_item(REQ_TICK, pack_req($urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom));
      end else begin
         send_item(REQ_SPARE, pack_req($urandom, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom));
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      rsp_tready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: unconfigured reject, then validation, timeouts seen and unseen and successful matches.
      send_item(REQ_CHECK, pack_req(32'h11, 32'h01, 32'd3, 0, 0, 0, 0));
      wait_idle();
      load_regs(32'd96, MODE_GE, 4'd8, 2'd0, 2'd1, 2'd2);
      send_item(REQ_CHECK, pack_req(32'h20, 32'h00, 32'd3, 0, 0, 0, 0));
      send_item(REQ_CHECK, pack_req(32'h21, 32'hf8, 32'd3, 0, 0, 0, 0));
      send_item(REQ_CHECK, pack_req(32'h22, 32'h0f, 32'd3, 0, 0, 0, 0));
      send_item(REQ_CHECK, pack_req(32'h23, 32'h01, 32'd0, 0, 0, 0, 0));
      send_item(REQ_CHECK, pack_req(32'h24, 32'h01, 32'd8640001, 0, 0, 0, 0));
      send_item(REQ_CHECK, pack_req(32'h25, 32'h01, 32'hffffff, 0, 0, 0, 0));
      send_item(REQ_CHECK, pack_req(32'hff, 32'h07, {8'd0, MAX_TIMEOUT}, 0, 0, 0, 0));
      send_item(REQ_CHECK, pack_req(32'h00, 32'h01, 32'd1, 0, 0, 0, 0));
      send_item(REQ_SAMPLE, pack_req(0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_item(REQ_TICK, '0);
      send_item(REQ_CHECK, pack_req(32'h01, 32'h02, 32'd2, 0, 0, 0, 0));
      send_item(REQ_SAMPLE, pack_req(0, 0, 0, 1, NO_PRESSURE, NO_PRESSURE, NO_PRESSURE));
      send_item(REQ_TICK, '0);
      send_item(REQ_TICK, '0);
      send_item(REQ_CHECK, pack_req(32'h02, 32'h03, 32'd5, 0, 0, 0, 0));
      send_item(REQ_SAMPLE, pack_req(0, 0, 0, 1, 32'h7fffffff, 32'd96, 32'd0));
      send_item(REQ_SAMPLE, pack_req(0, 0, 0, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_item(REQ_SPARE, '1);
      send_item(REQ_TICK, '0);

      // Random phases over register settings and idle patterns.
      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         case (ph)
            0: load_regs(32'd96, MODE_GE, 4'd8, 2'd0, 2'd1, 2'd2);
            1: load_regs(32'h7fffffff, MODE_LE, 4'd1, 2'd2, 2'd1, 2'd0);
            2: load_regs(32'h80000000, MODE_GE, 4'd15, 2'd3, 2'd3, 2'd1);
            3: load_regs($urandom, MODE_LE, 4'd4, 2'($urandom), 2'($urandom), 2'($urandom));
            4: load_regs(32'd0, MODE_SPARE, 4'd0, 2'd1, 2'd2, 2'd3);
            5: load_regs(32'hfffffff0, MODE_GE, 4'd8, 2'($urandom), 2'($urandom),
                         2'($urandom));
            6: load_regs(32'd96, MODE_OFF, 4'd2, 2'd0, 2'd0, 2'd0);
            default: load_regs(32'hfffffffb, MODE_LE, 4'd8, 2'd1, 2'd0, 2'd2);
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 66; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 66; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         repeat (58) send_random();
      end

      wait_idle();
      $display("covered %0d input transfers and %0d checked results over 9 register sets",
               sent_items, sb.matched);
      if (sb.errors == 0)
         $display("pending_suction_check_table verification clean");
      else
         $display("pending_suction_check_table verification failed");
      $finish;
   end
endmodule

### sim.f
+incdir+rtl
rtl/pscheck_pkg.sv
rtl/pscheck_ram.sv
rtl/pending_suction_check_table.sv
sim/pending_suction_check_table_tb.sv
